### rtl/stq_pkg.sv
// Shared types and constants for the sorted timer event queue.
`default_nettype none

package stq_pkg;

    // Size of the queue and the cap on events fired by one check.
    localparam int DEFAULT_QUEUE_DEPTH = 16;
    localparam int MAX_FIRE            = 16;
    localparam int FIRE_CNT_W          = $clog2(MAX_FIRE + 1);
    localparam int FIRE_IDX_W          = $clog2(MAX_FIRE);

    // Field widths.
    localparam int TICK_W     = 32;
    localparam int TIMEOUT_W  = 16;
    localparam int PROD_W     = TICK_W + TIMEOUT_W;
    localparam int TIME_W     = 64;
    localparam int ID_W       = 8;

    localparam logic [TICK_W-1:0] TICK_RATE_RESET = 32'd1000000;

    // Request codes.
    localparam logic REQ_CHECK = 1'b0;
    localparam logic REQ_ADD   = 1'b1;

    // Result kinds.
    typedef enum logic [1:0] {
        KIND_NONE  = 2'd0,
        KIND_FIRED = 2'd1,
        KIND_FULL  = 2'd2
    } t_kind;

    // Controller states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_SUM,
        S_CMP,
        S_INS,
        S_POP,
        S_EMIT,
        S_ACK,
        S_FULL
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic  load;
        logic  mul;
        logic  sum;
        logic  cmp;
        logic  ins;
        logic  pop;
        logic  emit;
        t_kind emit_kind;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic full;
        logic head_expired;
        logic fire_room;
        logic fire_any;
        logic emit_last;
    } t_dp_status;

endpackage

`default_nettype wire

### rtl/stq_ctrl.sv
// Controller state machine for the sorted timer event queue.
`default_nettype none

module stq_ctrl (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  start,
    input  wire                  i_req_type,
    input  stq_pkg::t_dp_status  i_status,
    output stq_pkg::t_dp_cmd     o_cmd,
    output logic                 busy
);

    stq_pkg::t_state r_state;
    stq_pkg::t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= stq_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            stq_pkg::S_IDLE: begin
                if (start) begin
                    if (i_req_type == stq_pkg::REQ_ADD) begin
                        n_state = i_status.full ? stq_pkg::S_FULL : stq_pkg::S_MUL;
                    end else begin
                        n_state = stq_pkg::S_POP;
                    end
                end
            end
            stq_pkg::S_MUL: n_state = stq_pkg::S_SUM;
            stq_pkg::S_SUM: n_state = stq_pkg::S_CMP;
            stq_pkg::S_CMP: n_state = stq_pkg::S_INS;
            stq_pkg::S_INS: n_state = stq_pkg::S_ACK;
            stq_pkg::S_POP: begin
                if (!(i_status.head_expired && i_status.fire_room)) begin
                    n_state = i_status.fire_any ? stq_pkg::S_EMIT : stq_pkg::S_ACK;
                end
            end
            stq_pkg::S_EMIT: begin
                if (i_status.emit_last) begin
                    n_state = stq_pkg::S_IDLE;
                end
            end
            stq_pkg::S_ACK:  n_state = stq_pkg::S_IDLE;
            stq_pkg::S_FULL: n_state = stq_pkg::S_IDLE;
            default:         n_state = stq_pkg::S_IDLE;
        endcase
    end

    // Commands for the datapath.
    always_comb begin
        o_cmd           = '0;
        o_cmd.emit_kind = stq_pkg::KIND_NONE;
        busy            = (r_state != stq_pkg::S_IDLE);
        case (r_state)
            stq_pkg::S_IDLE: o_cmd.load = start;
            stq_pkg::S_MUL:  o_cmd.mul  = 1'b1;
            stq_pkg::S_SUM:  o_cmd.sum  = 1'b1;
            stq_pkg::S_CMP:  o_cmd.cmp  = 1'b1;
            stq_pkg::S_INS:  o_cmd.ins  = 1'b1;
            stq_pkg::S_POP:  o_cmd.pop  = i_status.head_expired && i_status.fire_room;
            stq_pkg::S_EMIT: begin
                o_cmd.emit      = 1'b1;
                o_cmd.emit_kind = stq_pkg::KIND_FIRED;
            end
            stq_pkg::S_ACK: begin
                o_cmd.emit      = 1'b1;
                o_cmd.emit_kind = stq_pkg::KIND_NONE;
            end
            stq_pkg::S_FULL: begin
                o_cmd.emit      = 1'b1;
                o_cmd.emit_kind = stq_pkg::KIND_FULL;
            end
            default: o_cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

### rtl/stq_datapath.sv
// Datapath: deadline arithmetic, sorted queue cells, fire buffer and result registers.
`default_nettype none

module stq_datapath #(
    parameter int QUEUE_DEPTH = stq_pkg::DEFAULT_QUEUE_DEPTH
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_cfg_wr_en,
    input  wire  [stq_pkg::TICK_W-1:0]         i_cfg_wr_data,
    input  wire  [stq_pkg::ID_W-1:0]           i_event_id,
    input  wire  [stq_pkg::TIMEOUT_W-1:0]      i_timeout_seconds,
    input  wire  [stq_pkg::TIME_W-1:0]         i_now,
    input  stq_pkg::t_dp_cmd                   i_cmd,
    output stq_pkg::t_dp_status                o_status,
    output logic                               o_valid,
    output logic [1:0]                         o_kind,
    output logic [stq_pkg::ID_W-1:0]           o_fired_id,
    output logic                               o_last,
    output logic [stq_pkg::TIME_W-1:0]         o_next_deadline,
    output logic                               o_queue_empty
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [stq_pkg::TICK_W-1:0]     r_tick_rate;
    logic [stq_pkg::ID_W-1:0]       r_id;
    logic [stq_pkg::TIMEOUT_W-1:0]  r_timeout;
    logic [stq_pkg::TIME_W-1:0]     r_now;
    logic [stq_pkg::PROD_W-1:0]     r_prod;
    logic [stq_pkg::TIME_W-1:0]     r_dl;
    logic [QUEUE_DEPTH-1:0]         r_gt;
    logic [stq_pkg::TIME_W-1:0]     r_q_dl [QUEUE_DEPTH];
    logic [stq_pkg::ID_W-1:0]       r_q_id [QUEUE_DEPTH];
    logic [CNT_W-1:0]               r_count;
    logic [stq_pkg::ID_W-1:0]       r_fb [stq_pkg::MAX_FIRE];
    logic [stq_pkg::FIRE_CNT_W-1:0] r_fire_cnt;

    logic                           r_out_valid;
    stq_pkg::t_kind                 r_out_kind;
    logic [stq_pkg::ID_W-1:0]       r_out_id;
    logic                           r_out_last;
    logic [stq_pkg::TIME_W-1:0]     r_out_dl;
    logic                           r_out_empty;

    // Tick rate register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_rate <= stq_pkg::TICK_RATE_RESET;
        end else if (i_cfg_wr_en) begin
            r_tick_rate <= i_cfg_wr_data;
        end
    end

    // Input capture and deadline arithmetic: multiply, then add.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_id      <= i_event_id;
            r_timeout <= i_timeout_seconds;
            r_now     <= i_now;
        end
        if (i_cmd.mul) begin
            r_prod <= stq_pkg::PROD_W'(r_tick_rate) * stq_pkg::PROD_W'(r_timeout);
        end
        if (i_cmd.sum) begin
            r_dl <= r_now + stq_pkg::TIME_W'(r_prod);
        end
    end

    // Each cell flags whether it holds a later deadline than the new event.
    always_ff @(posedge i_clk) begin
        if (i_cmd.cmp) begin
            for (int i = 0; i < QUEUE_DEPTH; i++) begin
                r_gt[i] <= (CNT_W'(i) < r_count) && (r_q_dl[i] > r_dl);
            end
        end
    end

    // Queue cells: insert shifts later entries up, pop shifts all down by one.
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if (i_cmd.ins) begin
                if (i > 0 && r_gt[(i > 0) ? i - 1 : 0]) begin
                    r_q_dl[i] <= r_q_dl[(i > 0) ? i - 1 : 0];
                    r_q_id[i] <= r_q_id[(i > 0) ? i - 1 : 0];
                end else if (r_gt[i] || (CNT_W'(i) == r_count)) begin
                    r_q_dl[i] <= r_dl;
                    r_q_id[i] <= r_id;
                end
            end else if (i_cmd.pop && i < QUEUE_DEPTH - 1) begin
                r_q_dl[i] <= r_q_dl[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
                r_q_id[i] <= r_q_id[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
            end
        end
    end

    // Occupancy count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.ins) begin
            r_count <= r_count + CNT_W'(1);
        end else if (i_cmd.pop) begin
            r_count <= r_count - CNT_W'(1);
        end
    end

    // Fire buffer: ids are written in pop order and shifted out one per result.
    always_ff @(posedge i_clk) begin
        if (i_cmd.pop) begin
            r_fb[r_fire_cnt[stq_pkg::FIRE_IDX_W-1:0]] <= r_q_id[0];
        end else if (i_cmd.emit && i_cmd.emit_kind == stq_pkg::KIND_FIRED) begin
            for (int i = 0; i < stq_pkg::MAX_FIRE - 1; i++) begin
                r_fb[i] <= r_fb[i + 1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fire_cnt <= '0;
        end else if (i_cmd.load) begin
            r_fire_cnt <= '0;
        end else if (i_cmd.pop) begin
            r_fire_cnt <= r_fire_cnt + stq_pkg::FIRE_CNT_W'(1);
        end else if (i_cmd.emit && i_cmd.emit_kind == stq_pkg::KIND_FIRED) begin
            r_fire_cnt <= r_fire_cnt - stq_pkg::FIRE_CNT_W'(1);
        end
    end

    // Result registers, showing the queue head as it stands after the step.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= i_cmd.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_kind  <= i_cmd.emit_kind;
            r_out_id    <= (i_cmd.emit_kind == stq_pkg::KIND_FIRED) ? r_fb[0] : '0;
            r_out_last  <= (i_cmd.emit_kind != stq_pkg::KIND_FIRED) ||
                           (r_fire_cnt == stq_pkg::FIRE_CNT_W'(1));
            r_out_dl    <= (r_count != '0) ? r_q_dl[0] : '0;
            r_out_empty <= (r_count == '0);
        end
    end

    // Status for the controller.
    always_comb begin
        o_status.full         = (r_count == CNT_W'(QUEUE_DEPTH));
        o_status.head_expired = (r_count != '0) && (r_q_dl[0] <= r_now);
        o_status.fire_room    = (r_fire_cnt != stq_pkg::FIRE_CNT_W'(stq_pkg::MAX_FIRE));
        o_status.fire_any     = (r_fire_cnt != '0);
        o_status.emit_last    = (r_fire_cnt == stq_pkg::FIRE_CNT_W'(1));
    end

    assign o_valid         = r_out_valid;
    assign o_kind          = r_out_kind;
    assign o_fired_id      = r_out_id;
    assign o_last          = r_out_last;
    assign o_next_deadline = r_out_dl;
    assign o_queue_empty   = r_out_empty;

endmodule

`default_nettype wire

### rtl/sorted_timer_event_queue.sv
// Add: the request steps through the multiply, sum, compare, insert and ack states; its single
// result appears as busy drops. Check firing k events (k up to 16): a scan pops each expired
// head, then the k results come one per cycle with no gap and busy drops with the last (a check
// that fires nothing gives one result from the ack state). A full-queue reject gives one result.
// Reset is synchronous and active low: the queue empties, tick_rate returns to 1000000,
// and no clearing pass is needed. Results cannot be stalled by the receiver.
`default_nettype none

module sorted_timer_event_queue #(
    parameter int QUEUE_DEPTH = stq_pkg::DEFAULT_QUEUE_DEPTH
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_cfg_wr_en,
    input  wire  [stq_pkg::TICK_W-1:0]     i_cfg_wr_data,
    input  wire                            start,
    output logic                           busy,
    input  wire                            i_req_type,
    input  wire  [stq_pkg::ID_W-1:0]       i_event_id,
    input  wire  [stq_pkg::TIMEOUT_W-1:0]  i_timeout_seconds,
    input  wire  [stq_pkg::TIME_W-1:0]     i_now,
    output logic                           o_valid,
    output logic [1:0]                     o_kind,
    output logic [stq_pkg::ID_W-1:0]       o_fired_id,
    output logic                           o_last,
    output logic [stq_pkg::TIME_W-1:0]     o_next_deadline,
    output logic                           o_queue_empty
);

    stq_pkg::t_dp_cmd    cmd;
    stq_pkg::t_dp_status status;

    // Sequencer.
    stq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .i_req_type (i_req_type),
        .i_status   (status),
        .o_cmd      (cmd),
        .busy       (busy)
    );

    // Queue storage and arithmetic.
    stq_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_wr_data     (i_cfg_wr_data),
        .i_event_id        (i_event_id),
        .i_timeout_seconds (i_timeout_seconds),
        .i_now             (i_now),
        .i_cmd             (cmd),
        .o_status          (status),
        .o_valid           (o_valid),
        .o_kind            (o_kind),
        .o_fired_id        (o_fired_id),
        .o_last            (o_last),
        .o_next_deadline   (o_next_deadline),
        .o_queue_empty     (o_queue_empty)
    );

`ifndef SYNTH
    // An accepted word keeps the block busy in the following cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("block not busy after accepting a word");

    // A result that is not the last one is followed at once by another.
    a_burst_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |=> o_valid)
        else $error("gap inside a burst of fired events");

    // An empty queue reports a zero compare value.
    a_empty_deadline: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_queue_empty |-> o_next_deadline == '0)
        else $error("empty queue with nonzero deadline");

    // A rejected add is always a single result.
    a_full_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == stq_pkg::KIND_FULL |-> o_last)
        else $error("reject result not marked last");
`endif

endmodule

`default_nettype wire
